@@ rtl/core/md5_stream_hasher_assert.svh @@
// ----------------------------------------------------------------------------
// md5_stream_hasher_assert.svh
// Assertion macros used by the checker of the MD5 stream hasher.
// ----------------------------------------------------------------------------
`ifndef MD5_STREAM_HASHER_ASSERT_SVH
`define MD5_STREAM_HASHER_ASSERT_SVH

// Clocked property with reset disable.
`define MD5_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen at a clock edge.
`define MD5_NEVER(label, clk, rst_n, expr, msg) \
    `MD5_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

@@ rtl/core/md5_pkg.sv @@
// ----------------------------------------------------------------------------
// md5_pkg
// Types, constants and round tables of the MD5 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // What the datapath feeds into the rounds as message words.
    typedef enum logic [1:0] {
        MODE_DATA,   // stored block as written
        MODE_PAD1,   // partial block with the pad marker, length if it fits
        MODE_PAD2    // zeros and the bit length only
    } mode_t;

    typedef struct packed {
        logic        byte_we;
        logic        load_work;
        logic        rd_en;
        logic [5:0]  rd_round;
        logic        wk_en;
        logic [5:0]  wk_round;
        logic        round_en;
        logic [5:0]  exec_round;
        logic        fold;
        logic        restart;
        mode_t       mode;
        logic [1:0]  out_sel;
    } cmd_t;

    typedef struct packed {
        logic pos_last;   // the next byte completes a block
        logic pos_hi;     // 56 or more bytes held: length needs a second block
    } sts_t;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_shift(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word used by round r.
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] m;
        logic [3:0] g;
        m = r[3:0];
        case (r[5:4])
            2'd0:    g = m;
            2'd1:    g = 4'(m * 4'd5 + 4'd1);
            2'd2:    g = 4'(m * 4'd3 + 4'd5);
            default: g = 4'(m * 4'd7);
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/md5_stream_if.sv @@
// ----------------------------------------------------------------------------
// md5_stream_if
// Valid/ready channels of the MD5 stream hasher: byte input and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

interface md5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_final;

    modport source (output valid, output data_byte, output is_final, input ready);
    modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

`default_nettype wire

@@ rtl/core/md5_ctrl.sv @@
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer of the MD5 hasher: byte intake, round issue, padding, readout.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_is_final,
    output logic               in_ready,
    input  wire logic          out_ready,
    output logic               out_valid,
    output logic [1:0]         out_index,
    input  wire md5_pkg::sts_t sts,
    output md5_pkg::cmd_t      cmd
);

    localparam logic [6:0] ISS_ROUNDS = 7'd64;
    localparam logic [6:0] ISS_LAST   = 7'd65;
    localparam logic [1:0] IDX_LAST   = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FOLD,
        S_OUT
    } state_t;

    state_t         state_reg, state_next;
    logic [6:0]     iss_reg, iss_next;
    md5_pkg::mode_t mode_reg, mode_next;
    logic [1:0]     idx_reg, idx_next;

    logic       in_xfer;
    logic       out_xfer;
    logic [6:0] iss_m1;
    logic [6:0] iss_m2;

    assign in_xfer  = in_valid && (state_reg == S_IDLE);
    assign out_xfer = out_ready && (state_reg == S_OUT);
    assign iss_m1   = iss_reg - 7'd1;
    assign iss_m2   = iss_reg - 7'd2;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_index = idx_reg;

    // The round issue counter drives three pipeline steps: word read,
    // masking plus round constant, then the round itself.
    always_comb
    begin
        cmd            = '0;
        cmd.byte_we    = in_xfer && !in_is_final;
        cmd.load_work  = (state_reg == S_RUN) && (iss_reg == 7'd0);
        cmd.rd_en      = (state_reg == S_RUN) && (iss_reg < ISS_ROUNDS);
        cmd.rd_round   = iss_reg[5:0];
        cmd.wk_en      = (state_reg == S_RUN) && (iss_reg != 7'd0) && (iss_reg <= ISS_ROUNDS);
        cmd.wk_round   = iss_m1[5:0];
        cmd.round_en   = (state_reg == S_RUN) && (iss_reg > 7'd1);
        cmd.exec_round = iss_m2[5:0];
        cmd.fold       = (state_reg == S_FOLD);
        cmd.restart    = out_xfer && (idx_reg == IDX_LAST);
        cmd.mode       = mode_reg;
        cmd.out_sel    = idx_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        iss_next   = iss_reg;
        mode_next  = mode_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_is_final)
                    begin
                        mode_next  = md5_pkg::MODE_PAD1;
                        state_next = S_RUN;
                        iss_next   = 7'd0;
                    end
                    else if (sts.pos_last)
                    begin
                        mode_next  = md5_pkg::MODE_DATA;
                        state_next = S_RUN;
                        iss_next   = 7'd0;
                    end
                end
            end
            S_RUN:
            begin
                iss_next = iss_reg + 7'd1;
                if (iss_reg == ISS_LAST)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                if ((mode_reg == md5_pkg::MODE_PAD1) && sts.pos_hi)
                begin
                    mode_next  = md5_pkg::MODE_PAD2;
                    state_next = S_RUN;
                    iss_next   = 7'd0;
                end
                else if (mode_reg == md5_pkg::MODE_DATA)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_OUT;
                    idx_next   = 2'd0;
                end
            end
            S_OUT:
            begin
                if (out_xfer)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iss_reg   <= 7'd0;
            mode_reg  <= md5_pkg::MODE_DATA;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            iss_reg   <= iss_next;
            mode_reg  <= mode_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/md5_datapath.sv @@
// ----------------------------------------------------------------------------
// md5_datapath
// Block buffer, padding mask, MD5 round unit and chaining registers.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire md5_pkg::cmd_t cmd,
    input  wire logic [7:0]    data_byte,
    output md5_pkg::sts_t      sts,
    output logic [31:0]        digest_word
);

    // Block buffer: sixteen little-endian words with byte lanes.
    logic [3:0][7:0] block_mem_reg [16];

    logic [31:0] chain_reg [4];
    logic [5:0]  pos_reg;
    logic [60:0] count_reg;

    logic [31:0] mem_q_reg;
    logic [31:0] wk_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;

    logic [3:0]  wk_g;
    logic [31:0] msg_word;
    logic [63:0] bit_len;
    logic        len_here;
    logic [31:0] wk_next;

    logic [31:0] f_val;
    logic [31:0] sum;
    logic [63:0] sum_dbl;
    logic [31:0] t_val;

    assign sts.pos_last = (pos_reg == 6'd63);
    assign sts.pos_hi   = (pos_reg[5:3] == 3'b111);
    assign digest_word  = chain_reg[cmd.out_sel];
    assign bit_len      = {count_reg, 3'b000};
    assign wk_g         = md5_pkg::msg_index(cmd.wk_round);

    // Padding is applied on the fly as words leave the buffer, so bytes
    // at or above the fill position are never taken from storage.
    always_comb
    begin
        msg_word = '0;
        case (cmd.mode)
            md5_pkg::MODE_DATA:
            begin
                msg_word = mem_q_reg;
            end
            md5_pkg::MODE_PAD1:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if ({wk_g, 2'(k)} < pos_reg)
                    begin
                        msg_word[8*k +: 8] = mem_q_reg[8*k +: 8];
                    end
                    else if ({wk_g, 2'(k)} == pos_reg)
                    begin
                        msg_word[8*k +: 8] = md5_pkg::PAD_BYTE;
                    end
                end
            end
            default:
            begin
                msg_word = '0;
            end
        endcase
        len_here = (cmd.mode == md5_pkg::MODE_PAD2) ||
                   ((cmd.mode == md5_pkg::MODE_PAD1) && !sts.pos_hi);
        if (len_here && (wk_g[3:1] == 3'b111))
        begin
            msg_word = wk_g[0] ? bit_len[63:32] : bit_len[31:0];
        end
        wk_next = msg_word + md5_pkg::round_k(cmd.wk_round);
    end

    always_comb
    begin
        case (cmd.exec_round[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum     = a_reg + f_val + wk_reg;
        sum_dbl = {sum, sum} << md5_pkg::round_shift(cmd.exec_round);
        t_val   = b_reg + sum_dbl[63:32];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.byte_we)
        begin
            block_mem_reg[pos_reg[5:2]][pos_reg[1:0]] <= data_byte;
        end
        if (cmd.rd_en)
        begin
            mem_q_reg <= block_mem_reg[md5_pkg::msg_index(cmd.rd_round)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wk_en)
        begin
            wk_reg <= wk_next;
        end
        if (cmd.load_work)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end
        else if (cmd.round_en)
        begin
            a_reg <= d_reg;
            b_reg <= t_val;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= md5_pkg::IV_A;
            chain_reg[1] <= md5_pkg::IV_B;
            chain_reg[2] <= md5_pkg::IV_C;
            chain_reg[3] <= md5_pkg::IV_D;
            pos_reg      <= 6'd0;
            count_reg    <= 61'd0;
        end
        else if (cmd.restart)
        begin
            chain_reg[0] <= md5_pkg::IV_A;
            chain_reg[1] <= md5_pkg::IV_B;
            chain_reg[2] <= md5_pkg::IV_C;
            chain_reg[3] <= md5_pkg::IV_D;
            pos_reg      <= 6'd0;
            count_reg    <= 61'd0;
        end
        else
        begin
            if (cmd.byte_we)
            begin
                pos_reg   <= pos_reg + 6'd1;
                count_reg <= count_reg + 61'd1;
            end
            if (cmd.fold)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/md5_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// md5_stream_hasher
// MD5 digest of a byte stream with a valid/ready byte input and digest output.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one message byte per transfer with is_final low; a transfer
//   with is_final high closes the message (its data_byte is ignored).
//   out_ch then delivers the digest as four 32-bit words A, B, C, D with
//   word_index 0 to 3 and last_word high on the fourth.
// Flow:
//   Bytes are taken while in_ch.ready is high. The 64th byte of a block
//   starts a compression (round issue through the three-step round
//   pipeline, then the chaining add), during which in_ch.ready is low, so
//   no new byte is taken before the compression has finished. The closing
//   transfer runs one padded compression, or two when 56 or more bytes of
//   the last block are held, before the first digest word is valid.
// Reset and stalls:
//   Reset loads the MD5 initial values and clears the byte counters; no
//   clearing pass runs. While out_ch.ready is low the current word holds,
//   and no new byte is taken until the fourth word has been transferred,
//   after which the block is ready for the next message.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_stream_hasher (
    input  wire logic clk,
    input  wire logic rst_n,
    md5_in_if.sink    in_ch,
    md5_out_if.source out_ch
);

    md5_pkg::cmd_t cmd;
    md5_pkg::sts_t sts;
    logic [1:0]    out_index;

    md5_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_is_final (in_ch.is_final),
        .in_ready    (in_ch.ready),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_index   (out_index),
        .sts         (sts),
        .cmd         (cmd)
    );

    md5_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (in_ch.data_byte),
        .sts         (sts),
        .digest_word (out_ch.digest_word)
    );

    assign out_ch.word_index = out_index;
    assign out_ch.last_word  = (out_index == 2'd3);

endmodule

`default_nettype wire

@@ rtl/core/md5_stream_hasher_checker.sv @@
// ----------------------------------------------------------------------------
// md5_stream_hasher_checker
// Port-level checks of the MD5 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "md5_stream_hasher_assert.svh"

module md5_stream_hasher_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        in_is_final,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] digest_word,
    input wire logic [1:0]  word_index,
    input wire logic        last_word
);

    // A stalled digest word must not change under the receiver.
    `MD5_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(digest_word), "digest word changed while stalled")

    // Bytes are never taken while a digest is being read out.
    `MD5_NEVER(a_no_overlap, clk, rst_n, in_ready && out_valid, "input ready during digest readout")

    // Words of one digest follow each other without a gap in index.
    `MD5_ASSERT(a_index_step, clk, rst_n, out_valid && out_ready && !last_word |=> out_valid && (word_index == 2'($past(word_index) + 2'd1)), "digest word index skipped")

    `MD5_ASSERT(a_last_flag, clk, rst_n, out_valid |-> (last_word == (word_index == 2'd3)), "last word flag does not match index")

    // Closing a message starts padding, so the input must drop ready.
    `MD5_ASSERT(a_final_busy, clk, rst_n, in_valid && in_ready && in_is_final |=> !in_ready, "input still ready after closing transfer")

endmodule

bind md5_stream_hasher md5_stream_hasher_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_is_final (in_ch.is_final),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .digest_word (out_ch.digest_word),
    .word_index  (out_ch.word_index),
    .last_word   (out_ch.last_word)
);

`default_nettype wire
